// ===== hdl/bincoef_pkg.sv =====
`default_nettype none

package bincoef_pkg;

	localparam int unsigned N_W    = 6;
	localparam int unsigned I_W    = 5;
	localparam int unsigned COEF_W = 57;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned CNT_W  = 6;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_K_OVER_N = 2'd1;
	localparam logic [1:0] STATUS_N_RANGE  = 2'd2;

	typedef struct packed {
		logic [N_W-1:0] n_total;
		logic [N_W-1:0] k_chosen;
	} bincoef_req_t;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic [1:0]        status;
	} bincoef_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} bincoef_state_t;

endpackage

`default_nettype wire

// ===== hdl/binomial_coefficient.sv =====
`default_nettype none

// Binomial coefficient C(n_total, k_chosen), one result per request transaction.
// The block works on one request at a time and stalls requests while busy.
// With s = min(k, n-k), an in-range request with s >= 2 runs s rounds of a
// multiply by (max(k, n-k) + i) followed by a restoring divide over all 64
// product bits by i, one quotient bit per cycle, on a single shared divider.
// Errors and s <= 1 skip the rounds and go straight to the result.
// n above MAX_N gives status 2, k above n gives status 1, both with a zero
// coefficient. A finished result waits in an output register while stalled.
module binomial_coefficient
	import bincoef_pkg::*;
#(
	parameter int unsigned MAX_N = 60
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire bincoef_req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output bincoef_rsp_t      rsp
);

	bincoef_state_t state_q, state_d;

	logic [N_W-1:0]    big_q;
	logic [I_W-1:0]    small_q;
	logic [I_W-1:0]    i_q;
	logic [COEF_W-1:0] acc_q;
	logic [PROD_W-1:0] quot_q;
	logic [I_W-1:0]    rem_q;
	logic [CNT_W-1:0]  cnt_q;
	bincoef_rsp_t      res_q;
	bincoef_rsp_t      rsp_q;
	logic              rsp_valid_q;

	logic              req_fire;
	logic              load_out;
	logic              div_last;
	logic              round_last;
	logic [N_W-1:0]    diff;
	logic [N_W-1:0]    big_d;
	logic [N_W-1:0]    small_full;
	logic [N_W-1:0]    factor;
	logic [I_W:0]      trial;
	logic              qbit;
	logic [I_W-1:0]    rem_d;
	logic [PROD_W-1:0] quot_d;
	logic [N_W+COEF_W-1:0] prod;

	assign req_fire = req_valid && !req_stall;
	assign load_out = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// split n into the larger and smaller part of k and n-k
	assign diff       = req.n_total - req.k_chosen;
	assign big_d      = (diff > req.k_chosen) ? diff : req.k_chosen;
	assign small_full = req.n_total - big_d;

	assign factor = big_q + N_W'(i_q);
	assign prod   = acc_q * factor;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial  = {rem_q, quot_q[PROD_W-1]};
	assign qbit   = (trial >= {1'b0, i_q});
	assign rem_d  = qbit ? I_W'(trial - {1'b0, i_q}) : trial[I_W-1:0];
	assign quot_d = {quot_q[PROD_W-2:0], qbit};

	assign div_last   = (cnt_q == '0);
	assign round_last = (i_q == small_q);

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req.n_total > N_W'(MAX_N) || req.k_chosen > req.n_total
							|| small_full < N_W'(2)) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = round_last ? ST_FIN : ST_MUL;
				end
			end
			ST_FIN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					big_q   <= big_d;
					small_q <= small_full[I_W-1:0];
					i_q     <= I_W'(1);
					acc_q   <= COEF_W'(1);
					if (req.n_total > N_W'(MAX_N)) begin
						res_q.status      <= STATUS_N_RANGE;
						res_q.coefficient <= '0;
					end else if (req.k_chosen > req.n_total) begin
						res_q.status      <= STATUS_K_OVER_N;
						res_q.coefficient <= '0;
					end else if (small_full == '0) begin
						res_q.status      <= STATUS_OK;
						res_q.coefficient <= COEF_W'(1);
					end else begin
						// s = 1 gives n; larger s is overwritten by the loop
						res_q.status      <= STATUS_OK;
						res_q.coefficient <= COEF_W'(req.n_total);
					end
				end
			end
			ST_MUL: begin
				quot_q <= PROD_W'(prod);
				rem_q  <= '0;
				cnt_q  <= CNT_W'(PROD_W - 1);
			end
			ST_DIV: begin
				quot_q <= quot_d;
				rem_q  <= rem_d;
				cnt_q  <= cnt_q - CNT_W'(1);
				if (div_last) begin
					// exact division: quotient is C(big + i, i)
					acc_q <= quot_d[COEF_W-1:0];
					i_q   <= i_q + I_W'(1);
					if (round_last) begin
						res_q.coefficient <= quot_d[COEF_W-1:0];
					end
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
